[src/rsma_pkg.sv]
// ----------------------------------------------------------------------------
// rsma_pkg: shared types and constants of the rounded moving average block
// Field widths, register codes, reset values and the item structs that the
// top level and its RAMs use.
// ----------------------------------------------------------------------------
package rsma_pkg;

  // Field widths fixed by the item formats.
  localparam int CLOSE_W    = 24;
  localparam int DATE_W     = 27;
  localparam int TAG_W      = 24;
  localparam int LEN_CFG_W  = 9;
  localparam int WIN_IDX_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  // Default ring depth.
  localparam int MAX_WINDOW_DEF = 256;

  // Register reset values.
  localparam logic [LEN_CFG_W-1:0] WINDOW_LENGTH_RST     = LEN_CFG_W'(5);
  localparam logic [DATE_W-1:0]    START_DATE_LIMIT_RST  = '0;
  localparam logic [WIN_IDX_W-1:0] LAST_WINDOW_INDEX_RST = WIN_IDX_W'(31);
  localparam logic [TAG_W-1:0]     SERIES_TAG_RST        = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH     = 2'd0,
    CFG_START_DATE_LIMIT  = 2'd1,
    CFG_LAST_WINDOW_INDEX = 2'd2,
    CFG_SERIES_TAG        = 2'd3
  } cfg_reg_t;

  // One input item: a daily close and its date.
  typedef struct packed {
    logic [CLOSE_W-1:0] close_price;
    logic [DATE_W-1:0]  trade_date;
    logic               series_start;
  } in_item_t;

  // One result item: a window's newest date and its rounded mean.
  typedef struct packed {
    logic [DATE_W-1:0]  window_date;
    logic [CLOSE_W-1:0] average;
    logic [TAG_W-1:0]   tag;
  } out_item_t;

endpackage

[src/rounded_simple_moving_average.sv]
// ----------------------------------------------------------------------------
// rounded_simple_moving_average: rounded moving average of daily closes
// Keeps the latest closes and dates in two RAM rings, sums each full window
// and divides by its length with a shared restoring divider.
// ----------------------------------------------------------------------------
// Items arrive newest first; each one is written into the rings, and once the
// series holds at least window_length closes the window sum is rebuilt from
// the ring, one RAM read per cycle, and rounded to floor((2*sum+len)/(2*len))
// by a one-bit-per-cycle divider. An item passes through the ring sweep, a
// drain step for the registered read, a check step, the divider steps and an
// emit step that loads the result register; item_stall holds the input until
// the item is through. The load waits while a stalled result still holds the
// output register, so the item takes longer by that stall. A window that is
// not reported ends after the check step, and an item that does not yet
// complete a window is only written into the rings. The ring sweep through the
// single RAM read port and the divider set the item time. The block takes the
// next item while a result still waits in its output register.
// Configuration writes are always accepted and must be made while idle.
// ----------------------------------------------------------------------------
module rounded_simple_moving_average
  import rsma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items.
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  // Result items.
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = CLOSE_W + PTR_W;
  localparam int DVD_W  = SUM_W + 1;
  localparam int DVS_W  = LEN_W + 1;
  localparam int DCNT_W = $clog2(DVD_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LEN_CFG_W-1:0] cfg_window_length;
  logic [DATE_W-1:0]    cfg_start_date_limit;
  logic [WIN_IDX_W-1:0] cfg_last_window_index;
  logic [TAG_W-1:0]     cfg_series_tag;

  // Series state.
  logic [PTR_W-1:0]     ptr;
  logic [LEN_W-1:0]     items_seen;
  logic [WIN_IDX_W-1:0] win_idx;
  logic                 series_done;

  // Per-item working registers.
  logic [LEN_W-1:0]     len_q;
  logic [PTR_W-1:0]     rd_cnt;
  logic                 rd_valid;
  logic [SUM_W-1:0]     sum;
  logic [DATE_W-1:0]    wdate;
  logic                 stop_q;
  logic [DVD_W-1:0]     dvd;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [DCNT_W-1:0]    div_cnt;

  logic                 item_accept;
  logic [LEN_W-1:0]     len_eff;
  logic [PTR_W-1:0]     ptr_inc;
  logic [PTR_W-1:0]     ptr_new;
  logic [LEN_W-1:0]     seen_base;
  logic [LEN_W-1:0]     seen_new;
  logic [PTR_W:0]       slot_wide;
  logic [PTR_W-1:0]     rd_addr;
  logic [CLOSE_W-1:0]   rd_close;
  logic [DATE_W-1:0]    rd_date;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_diff;
  logic                 q_bit;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;

  // Effective window length: zero counts as one, long lengths clamp to the ring.
  always_comb begin
    if (cfg_window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg_window_length) > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(cfg_window_length);
    end
  end

  // Ring pointer and fill count for the item being accepted.
  always_comb begin
    ptr_inc = (ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr + 1'b1;
    if (item.series_start) begin
      ptr_new = '0;
    end else if (items_seen != '0) begin
      ptr_new = ptr_inc;
    end else begin
      ptr_new = ptr;
    end
    seen_base = item.series_start ? '0 : items_seen;
    seen_new  = (32'(seen_base) < 32'(MAX_WINDOW)) ? seen_base + 1'b1 : seen_base;
  end

  // Ring slot rd_cnt steps behind the newest item.
  always_comb begin
    if (ptr >= rd_cnt) begin
      slot_wide = {1'b0, ptr} - {1'b0, rd_cnt};
    end else begin
      slot_wide = {1'b0, ptr} + (PTR_W + 1)'(MAX_WINDOW) - {1'b0, rd_cnt};
    end
    rd_addr = slot_wide[PTR_W-1:0];
  end

  // One restoring divider step.
  always_comb begin
    rem_sh   = {rem, dvd[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    q_bit    = (rem_sh >= {1'b0, dvs});
  end

  rsma_ram #(
    .WIDTH (CLOSE_W),
    .DEPTH (MAX_WINDOW)
  ) u_close_ring (
    .clk     (clk),
    .wr_en   (item_accept),
    .wr_addr (ptr_new),
    .wr_data (item.close_price),
    .rd_addr (rd_addr),
    .rd_data (rd_close)
  );

  rsma_ram #(
    .WIDTH (DATE_W),
    .DEPTH (MAX_WINDOW)
  ) u_date_ring (
    .clk     (clk),
    .wr_en   (item_accept),
    .wr_addr (ptr_new),
    .wr_data (item.trade_date),
    .rd_addr (rd_addr),
    .rd_data (rd_date)
  );

  // Sequencer, series state, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= ST_IDLE;
      ptr                   <= '0;
      items_seen            <= '0;
      win_idx               <= '0;
      series_done           <= 1'b0;
      rd_valid              <= 1'b0;
      result_valid          <= 1'b0;
      cfg_window_length     <= WINDOW_LENGTH_RST;
      cfg_start_date_limit  <= START_DATE_LIMIT_RST;
      cfg_last_window_index <= LAST_WINDOW_INDEX_RST;
      cfg_series_tag        <= SERIES_TAG_RST;
    end else begin
      // Configuration writes.
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_WINDOW_LENGTH:     cfg_window_length     <= cfg_data[LEN_CFG_W-1:0];
          CFG_START_DATE_LIMIT:  cfg_start_date_limit  <= cfg_data[DATE_W-1:0];
          CFG_LAST_WINDOW_INDEX: cfg_last_window_index <= cfg_data[WIN_IDX_W-1:0];
          CFG_SERIES_TAG:        cfg_series_tag        <= cfg_data[TAG_W-1:0];
          default: ;
        endcase
      end

      // Accumulate ring data one read after its address was issued.
      rd_valid <= (state == ST_READ);
      if (rd_valid) begin
        sum   <= sum + SUM_W'(rd_close);
        wdate <= rd_date;
      end

      // Result register drains when the receiver takes the item; in the emit
      // step the load below decides its next value.
      if (result_valid && !result_stall && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_accept) begin
            ptr        <= ptr_new;
            items_seen <= seen_new;
            if (item.series_start) begin
              win_idx     <= '0;
              series_done <= 1'b0;
            end
            len_q  <= len_eff;
            rd_cnt <= '0;
            sum    <= '0;
            state  <= (seen_new < len_eff) ? ST_IDLE : ST_READ;
          end
        end
        ST_READ: begin
          if (LEN_W'(rd_cnt) == len_q - 1'b1) begin
            state <= ST_DRAIN;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          // The window index is used up even when nothing is emitted.
          if (win_idx != '1) begin
            win_idx <= win_idx + 1'b1;
          end
          if (series_done || (wdate < cfg_start_date_limit)) begin
            state <= ST_IDLE;
          end else begin
            stop_q  <= (win_idx >= cfg_last_window_index);
            dvd     <= {sum, 1'b0} + DVD_W'(len_q);
            dvs     <= {len_q, 1'b0};
            rem     <= '0;
            div_cnt <= DCNT_W'(DVD_W - 1);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= q_bit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
          dvd <= {dvd[DVD_W-2:0], q_bit};
          if (div_cnt == '0) begin
            state <= ST_EMIT;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_EMIT: begin
          // Load the result once the output register is free.
          if (!result_valid || !result_stall) begin
            result.window_date <= wdate;
            result.average     <= dvd[CLOSE_W-1:0];
            result.tag         <= cfg_series_tag;
            result_valid       <= 1'b1;
            if (stop_q) begin
              series_done <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result appears only from the emit step.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside the emit step");

  // The divider remainder stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dvs))
    else $error("divider remainder out of range");

  // The ring sweep never reads past the window.
  a_sweep_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (LEN_W'(rd_cnt) < len_q))
    else $error("ring sweep beyond window length");

endmodule

[src/rsma_ram.sv]
// ----------------------------------------------------------------------------
// rsma_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rsma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
